FILE: src/laser_line_column_centroid_assert.svh
// assertion macros for the laser line column centroid block
`ifndef LASER_LINE_COLUMN_CENTROID_ASSERT_SVH
`define LASER_LINE_COLUMN_CENTROID_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define LLCC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("llcc assertion failed");
// next-cycle implication
`define LLCC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("llcc assertion failed");
`else
`define LLCC_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define LLCC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

FILE: src/llcc_pkg.sv
package llcc_pkg;

   localparam int MAX_ROWS    = 1024;
   localparam int MAX_COLUMNS = 2048;

   localparam int GRAY_W    = 8;
   localparam int HALF_W    = 4;
   localparam int FRAC_W    = 8;
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
   localparam int SPAN_W    = ROW_CNT_W + 1;
   localparam int COL_W     = $clog2(MAX_COLUMNS);
   localparam int FIX_W     = ROW_W + FRAC_W;
   localparam int WIN_MAX   = 2 * ((1 << HALF_W) - 1);
   localparam int WIN_CNT_W = $clog2(WIN_MAX + 1);
   localparam int SUM_W     = $clog2(WIN_MAX * 255 + 1);
   localparam int WSUM_W    = $clog2(WIN_MAX * 255 * (MAX_ROWS - 1) + 1);
   localparam int STEP_W    = $clog2(FIX_W + 1);
   localparam int STORE_AW  = ROW_W + 1;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [GRAY_W-1:0] THRESHOLD_RESET  = 8'd128;
   localparam logic [ROW_W-1:0]  LOW_BOUND_RESET  = ROW_W'(5);
   localparam logic [ROW_W-1:0]  HIGH_BOUND_RESET = ROW_W'(240);
   localparam logic [HALF_W-1:0] HALF_RESET       = 4'd5;

   typedef enum logic [1:0] {
      REG_THRESHOLD  = 2'd0,
      REG_LOW_BOUND  = 2'd1,
      REG_HIGH_BOUND = 2'd2,
      REG_HALF       = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [GRAY_W-1:0] threshold;
      logic [ROW_W-1:0]  low_bound;
      logic [ROW_W-1:0]  high_bound;
      logic [HALF_W-1:0] half;
   } cfg_type;

   // one finished column handed from front to back
   typedef struct packed {
      logic                 bank;
      logic [COL_W-1:0]     column;
      logic [ROW_W-1:0]     peak_row;
      logic [GRAY_W-1:0]    peak_gray;
      logic [ROW_CNT_W-1:0] rows;
   } job_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [GRAY_W-1:0]   data;
   } store_wr_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

endpackage

FILE: src/llcc_job_fifo.sv
module llcc_job_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  llcc_pkg::job_type push_job,
   input  logic             pop,
   output llcc_pkg::job_type head_job,
   output logic             empty,
   output logic             full
);

   llcc_pkg::job_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      empty     = (count_ff == 2'd0);
      full      = (count_ff == 2'd2);
      head_job  = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: src/llcc_store.sv
module llcc_store (
   input  logic                                 clock,
   input  llcc_pkg::store_wr_type               wr,
   input  logic                                 rd_en,
   input  logic [llcc_pkg::STORE_AW-1:0]        rd_addr,
   output logic [llcc_pkg::GRAY_W-1:0]          rd_data
);

   // two banks of one column each, bank is the top address bit
   logic [llcc_pkg::GRAY_W-1:0] mem_ff [2 * llcc_pkg::MAX_ROWS];
   logic [llcc_pkg::GRAY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/llcc_front.sv
module llcc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [llcc_pkg::GRAY_W-1:0]       pixel_gray,
   input  logic                              column_end,
   input  logic                              frame_end,
   input  llcc_pkg::release_type             release_bank,
   output llcc_pkg::store_wr_type            wr,
   output logic                              job_push,
   output llcc_pkg::job_type                 job,
   output logic [1:0]                        busy
);

   logic [llcc_pkg::ROW_CNT_W-1:0] row_cnt_ff, row_cnt_in;
   logic [llcc_pkg::GRAY_W-1:0]    best_gray_ff, best_gray_in;
   logic [llcc_pkg::ROW_W-1:0]     best_row_ff, best_row_in;
   logic [llcc_pkg::COL_W-1:0]     column_ff, column_in;
   logic                           bank_ff, bank_in;
   logic [1:0]                     busy_ff, busy_in;

   logic                           accept;
   logic                           room;
   logic                           better;
   logic [llcc_pkg::GRAY_W-1:0]    gray_next;
   logic [llcc_pkg::ROW_W-1:0]     row_next;
   logic [llcc_pkg::ROW_CNT_W-1:0] rows_next;

   always_comb begin
      full   = busy_ff[bank_ff];
      accept = push & ~full;
      room   = (row_cnt_ff < llcc_pkg::ROW_CNT_W'(llcc_pkg::MAX_ROWS));
      better = (pixel_gray > best_gray_ff);

      gray_next = (room && better) ? pixel_gray : best_gray_ff;
      row_next  = (room && better) ? row_cnt_ff[llcc_pkg::ROW_W-1:0] : best_row_ff;
      rows_next = room ? row_cnt_ff + 1'b1 : row_cnt_ff;

      wr.en   = accept & room;
      wr.addr = {bank_ff, row_cnt_ff[llcc_pkg::ROW_W-1:0]};
      wr.data = pixel_gray;

      job_push      = accept & column_end;
      job.bank      = bank_ff;
      job.column    = column_ff;
      job.peak_row  = row_next;
      job.peak_gray = gray_next;
      job.rows      = rows_next;

      row_cnt_in   = row_cnt_ff;
      best_gray_in = best_gray_ff;
      best_row_in  = best_row_ff;
      column_in    = column_ff;
      bank_in      = bank_ff;
      busy_in      = busy_ff;

      if (release_bank.valid) begin
         busy_in[release_bank.bank] = 1'b0;
      end

      if (accept) begin
         if (column_end) begin
            // column closes: hand the bank to the back end
            row_cnt_in   = '0;
            best_gray_in = '0;
            best_row_in  = '0;
            bank_in      = ~bank_ff;
            busy_in[bank_ff] = 1'b1;
            if (frame_end ||
                column_ff == llcc_pkg::COL_W'(llcc_pkg::MAX_COLUMNS - 1)) begin
               column_in = '0;
            end else begin
               column_in = column_ff + 1'b1;
            end
         end else begin
            row_cnt_in   = rows_next;
            best_gray_in = gray_next;
            best_row_in  = row_next;
         end
      end

      busy = busy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff   <= '0;
         best_gray_ff <= '0;
         best_row_ff  <= '0;
         column_ff    <= '0;
         bank_ff      <= 1'b0;
         busy_ff      <= 2'b00;
      end else begin
         row_cnt_ff   <= row_cnt_in;
         best_gray_ff <= best_gray_in;
         best_row_ff  <= best_row_in;
         column_ff    <= column_in;
         bank_ff      <= bank_in;
         busy_ff      <= busy_in;
      end
   end

endmodule

FILE: src/llcc_back.sv
module llcc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  llcc_pkg::cfg_type                 cfg,
   input  llcc_pkg::job_type                 head_job,
   input  logic                              job_empty,
   output logic                              job_pop,
   output logic                              rd_en,
   output logic [llcc_pkg::STORE_AW-1:0]     rd_addr,
   input  logic [llcc_pkg::GRAY_W-1:0]       rd_data,
   output llcc_pkg::release_type             release_bank,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [llcc_pkg::COL_W-1:0]        rsp_column_number,
   output logic [llcc_pkg::ROW_W-1:0]        rsp_peak_row,
   output logic [llcc_pkg::GRAY_W-1:0]       rsp_peak_gray,
   output logic                              rsp_line_found,
   output logic                              rsp_center_valid,
   output logic [llcc_pkg::FIX_W-1:0]        rsp_center_row_fixed
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } back_state_type;

   back_state_type                   state_ff, state_in;
   llcc_pkg::job_type                job_ff, job_in;
   logic                             found_ff, found_in;
   logic                             valid_ff, valid_in;
   logic [llcc_pkg::ROW_W-1:0]       j_ff, j_in;
   logic [llcc_pkg::ROW_W-1:0]       j_dly_ff, j_dly_in;
   logic [llcc_pkg::WIN_CNT_W-1:0]   left_ff, left_in;
   logic                             rd_valid_ff, rd_valid_in;
   logic [llcc_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [llcc_pkg::WSUM_W-1:0]      wsum_ff, wsum_in;
   logic [llcc_pkg::SUM_W-1:0]       rem_ff, rem_in;
   logic [llcc_pkg::FIX_W-1:0]       numer_ff, numer_in;
   logic [llcc_pkg::FIX_W-1:0]       quot_ff, quot_in;
   logic [llcc_pkg::STEP_W-1:0]      steps_ff, steps_in;

   logic                             out_valid_ff, out_valid_in;
   logic [llcc_pkg::COL_W-1:0]       out_column_ff, out_column_in;
   logic [llcc_pkg::ROW_W-1:0]       out_row_ff, out_row_in;
   logic [llcc_pkg::GRAY_W-1:0]      out_gray_ff, out_gray_in;
   logic                             out_found_ff, out_found_in;
   logic                             out_cvalid_ff, out_cvalid_in;
   logic [llcc_pkg::FIX_W-1:0]       out_fixed_ff, out_fixed_in;

   logic                             found;
   logic                             win_ok;
   logic [llcc_pkg::SPAN_W-1:0]      p_ext;
   logic [llcc_pkg::SPAN_W-1:0]      h_ext;
   logic [llcc_pkg::GRAY_W+llcc_pkg::ROW_W-1:0] prod;
   logic [llcc_pkg::SUM_W:0]         trial;
   logic [llcc_pkg::SUM_W:0]         diff;
   logic                             ge;

   always_comb begin
      // window checks on the queue head
      p_ext  = llcc_pkg::SPAN_W'(head_job.peak_row);
      h_ext  = llcc_pkg::SPAN_W'(cfg.half);
      found  = (head_job.peak_gray > cfg.threshold);
      win_ok = (cfg.half != '0) &&
               (head_job.peak_row > cfg.low_bound) &&
               (head_job.peak_row < cfg.high_bound) &&
               (p_ext >= h_ext) &&
               (p_ext + h_ext <= llcc_pkg::SPAN_W'(head_job.rows));

      prod  = rd_data * j_dly_ff;
      trial = {rem_ff, numer_ff[llcc_pkg::FIX_W-1]};
      diff  = trial - {1'b0, sum_ff};
      ge    = (trial >= {1'b0, sum_ff});

      state_in    = state_ff;
      job_in      = job_ff;
      found_in    = found_ff;
      valid_in    = valid_ff;
      j_in        = j_ff;
      j_dly_in    = j_dly_ff;
      left_in     = left_ff;
      sum_in      = sum_ff;
      wsum_in     = wsum_ff;
      rem_in      = rem_ff;
      numer_in    = numer_ff;
      quot_in     = quot_ff;
      steps_in    = steps_ff;
      job_pop     = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = {job_ff.bank, j_ff};
      release_bank.valid = 1'b0;
      release_bank.bank  = job_ff.bank;

      out_valid_in  = out_valid_ff & ~rsp_pop;
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      out_gray_in   = out_gray_ff;
      out_found_in  = out_found_ff;
      out_cvalid_in = out_cvalid_ff;
      out_fixed_in  = out_fixed_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = head_job;
               found_in = found;
               if (found && win_ok) begin
                  j_in     = head_job.peak_row - llcc_pkg::ROW_W'(cfg.half);
                  left_in  = llcc_pkg::WIN_CNT_W'({cfg.half, 1'b0});
                  sum_in   = '0;
                  wsum_in  = '0;
                  state_in = ST_READ;
               end else begin
                  // nothing to read: free the bank at once
                  valid_in = 1'b0;
                  quot_in  = '0;
                  release_bank.valid = 1'b1;
                  release_bank.bank  = head_job.bank;
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            rd_en = (left_ff != '0);
            if (rd_en) begin
               j_in     = j_ff + 1'b1;
               j_dly_in = j_ff;
               left_in  = left_ff - 1'b1;
            end
            if (rd_valid_ff) begin
               sum_in  = sum_ff + llcc_pkg::SUM_W'(rd_data);
               wsum_in = wsum_ff + llcc_pkg::WSUM_W'(prod);
            end
            if (left_ff == '0 && !rd_valid_ff) begin
               release_bank.valid = 1'b1;
               if (sum_ff == '0) begin
                  valid_in = 1'b0;
                  quot_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  // top bits of wsum << FRAC_W start the remainder
                  rem_in   = llcc_pkg::SUM_W'(wsum_ff >> llcc_pkg::ROW_W);
                  numer_in = {wsum_ff[llcc_pkg::ROW_W-1:0], llcc_pkg::FRAC_W'(0)};
                  quot_in  = '0;
                  steps_in = llcc_pkg::STEP_W'(llcc_pkg::FIX_W);
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            rem_in   = ge ? diff[llcc_pkg::SUM_W-1:0] : trial[llcc_pkg::SUM_W-1:0];
            numer_in = {numer_ff[llcc_pkg::FIX_W-2:0], 1'b0};
            quot_in  = {quot_ff[llcc_pkg::FIX_W-2:0], ge};
            steps_in = steps_ff - 1'b1;
            if (steps_ff == llcc_pkg::STEP_W'(1)) begin
               valid_in = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in  = 1'b1;
               out_column_in = job_ff.column;
               out_row_in    = job_ff.peak_row;
               out_gray_in   = job_ff.peak_gray;
               out_found_in  = found_ff;
               out_cvalid_in = valid_ff;
               out_fixed_in  = valid_ff ? quot_ff : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_valid_in = rd_en;

      rsp_empty            = ~out_valid_ff;
      rsp_column_number    = out_column_ff;
      rsp_peak_row         = out_row_ff;
      rsp_peak_gray        = out_gray_ff;
      rsp_line_found       = out_found_ff;
      rsp_center_valid     = out_cvalid_ff;
      rsp_center_row_fixed = out_fixed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      found_ff      <= found_in;
      valid_ff      <= valid_in;
      j_ff          <= j_in;
      j_dly_ff      <= j_dly_in;
      left_ff       <= left_in;
      sum_ff        <= sum_in;
      wsum_ff       <= wsum_in;
      rem_ff        <= rem_in;
      numer_ff      <= numer_in;
      quot_ff       <= quot_in;
      steps_ff      <= steps_in;
      out_column_ff <= out_column_in;
      out_row_ff    <= out_row_in;
      out_gray_ff   <= out_gray_in;
      out_found_ff  <= out_found_in;
      out_cvalid_ff <= out_cvalid_in;
      out_fixed_ff  <= out_fixed_in;
   end

endmodule

FILE: src/laser_line_column_centroid.sv
// Laser line column centroid. Gray pixels of one column arrive top row first, one
// transaction per clock while req_full is low, and the transaction with column_end
// closes the column and yields one result transaction: column number, first
// brightest row and its value, line_found when the peak exceeds line_threshold,
// and, when the line is found, the peak row lies strictly between the bounds and
// rows peak-h to peak+h-1 are inside the column, the gray centroid in unsigned 10.8
// fixed point (truncated). The front end takes one pixel every cycle while req_full
// is low and writes it into one of two column banks. A closed column is queued for
// the back end, which reads its 2h window from the bank (one read per cycle), then
// runs an 18-step restoring divider, one quotient bit per cycle, and leaves the
// result in an output register. req_full rises only when the front end would need
// the bank the back end still reads, i.e. when two closed columns are pending; with
// columns longer than the back end's work per column pixel input never stalls. No
// clearing pass is needed after reset.
`include "laser_line_column_centroid_assert.svh"

module laser_line_column_centroid (
   input  logic                               clock,
   input  logic                               reset,

   // pixel input
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [llcc_pkg::GRAY_W-1:0]        req_pixel_gray,
   input  logic                               req_column_end,
   input  logic                               req_frame_end,

   // column results
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [llcc_pkg::COL_W-1:0]         rsp_column_number,
   output logic [llcc_pkg::ROW_W-1:0]         rsp_peak_row,
   output logic [llcc_pkg::GRAY_W-1:0]        rsp_peak_gray,
   output logic                               rsp_line_found,
   output logic                               rsp_center_valid,
   output logic [llcc_pkg::FIX_W-1:0]         rsp_center_row_fixed,

   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [llcc_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [llcc_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [llcc_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                               csr_pready
);

   // configuration registers
   llcc_pkg::cfg_type       cfg_ff, cfg_in;
   llcc_pkg::reg_index_type reg_index;
   logic                    csr_write;

   // front to back plumbing
   llcc_pkg::store_wr_type  store_wr;
   llcc_pkg::job_type       push_job;
   llcc_pkg::job_type       head_job;
   llcc_pkg::release_type   release_bank;
   logic                    job_push;
   logic                    job_pop;
   logic                    job_empty;
   logic                    job_full;
   logic [1:0]              bank_busy;
   logic                    rd_en;
   logic [llcc_pkg::STORE_AW-1:0] rd_addr;
   logic [llcc_pkg::GRAY_W-1:0]   rd_data;

   // register decode, byte address 4*i, writes complete in the access phase
   always_comb begin
      csr_pready = 1'b1;
      csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
      reg_index  = llcc_pkg::reg_index_type'(csr_paddr[3:2]);
      cfg_in     = cfg_ff;
      csr_prdata = '0;
      case (reg_index)
         llcc_pkg::REG_THRESHOLD: begin
            csr_prdata = llcc_pkg::CSR_DW'(cfg_ff.threshold);
            if (csr_write) cfg_in.threshold = csr_pwdata[llcc_pkg::GRAY_W-1:0];
         end
         llcc_pkg::REG_LOW_BOUND: begin
            csr_prdata = llcc_pkg::CSR_DW'(cfg_ff.low_bound);
            if (csr_write) cfg_in.low_bound = csr_pwdata[llcc_pkg::ROW_W-1:0];
         end
         llcc_pkg::REG_HIGH_BOUND: begin
            csr_prdata = llcc_pkg::CSR_DW'(cfg_ff.high_bound);
            if (csr_write) cfg_in.high_bound = csr_pwdata[llcc_pkg::ROW_W-1:0];
         end
         llcc_pkg::REG_HALF: begin
            csr_prdata = llcc_pkg::CSR_DW'(cfg_ff.half);
            if (csr_write) cfg_in.half = csr_pwdata[llcc_pkg::HALF_W-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold  <= llcc_pkg::THRESHOLD_RESET;
         cfg_ff.low_bound  <= llcc_pkg::LOW_BOUND_RESET;
         cfg_ff.high_bound <= llcc_pkg::HIGH_BOUND_RESET;
         cfg_ff.half       <= llcc_pkg::HALF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: pixel intake, peak tracking, bank ownership
   llcc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .full         (req_full),
      .pixel_gray   (req_pixel_gray),
      .column_end   (req_column_end),
      .frame_end    (req_frame_end),
      .release_bank (release_bank),
      .wr           (store_wr),
      .job_push     (job_push),
      .job          (push_job),
      .busy         (bank_busy)
   );

   // two column banks
   llcc_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // closed columns waiting for the centroid unit
   llcc_job_fifo u_job_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .empty    (job_empty),
      .full     (job_full)
   );

   // back end: window sums, divider, result register
   llcc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .head_job             (head_job),
      .job_empty            (job_empty),
      .job_pop              (job_pop),
      .rd_en                (rd_en),
      .rd_addr              (rd_addr),
      .rd_data              (rd_data),
      .release_bank         (release_bank),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_column_number    (rsp_column_number),
      .rsp_peak_row         (rsp_peak_row),
      .rsp_peak_gray        (rsp_peak_gray),
      .rsp_line_found       (rsp_line_found),
      .rsp_center_valid     (rsp_center_valid),
      .rsp_center_row_fixed (rsp_center_row_fixed)
   );

   // bank ownership keeps the column queue from overflowing
   `LLCC_ASSERT_IMPLY(a_job_no_overflow, clock, reset, job_push, !job_full)
   // the back end only frees a bank that it owns
   `LLCC_ASSERT_IMPLY(a_release_owned, clock, reset, release_bank.valid,
                      bank_busy[release_bank.bank])
   // a freed bank is free in the next cycle
   `LLCC_ASSERT_NEXT(a_release_clears, clock, reset, release_bank.valid,
                     !bank_busy[$past(release_bank.bank)])
   // a centroid only comes with a found line, and is zero otherwise
   `LLCC_ASSERT_IMPLY(a_center_consistent, clock, reset, !rsp_empty,
                      (!rsp_center_valid || rsp_line_found) &&
                      (rsp_center_valid || rsp_center_row_fixed == '0))

endmodule
